[rtl/nj_pkg.sv]
// Shared types, widths and arithmetic helpers for the neighbour-joining tree builder.
// Used by nj_engine, neighbor_joining_tree and nj_checker; depends on nothing else.
package nj_pkg;

	localparam int IDX_W  = 6;
	localparam int NODE_W = 7;
	localparam int CNT_W  = 7;
	localparam int DIST_W = 24;
	localparam int LEN_W  = 24;
	localparam int CELL_W = 32;
	localparam int WIDE_W = 40;
	localparam int IN_W   = 40;
	localparam int OUT_W  = 72;

	typedef struct packed {
		logic                     last_entry;
		logic signed [DIST_W-1:0] distance_value;
		logic [IDX_W-1:0]         col_index;
		logic [IDX_W-1:0]         row_index;
	} load_t;

	typedef struct packed {
		logic              last_join;
		logic [NODE_W-1:0] new_node;
		logic [LEN_W-1:0]  right_length;
		logic [LEN_W-1:0]  left_length;
		logic [NODE_W-1:0] right_node;
		logic [NODE_W-1:0] left_node;
	} result_t;

	typedef enum logic [26:0] {
		S_IDLE     = 27'h1 << 0,
		S_SUM_INIT = 27'h1 << 1,
		S_SUM_RD   = 27'h1 << 2,
		S_SUM_ACC  = 27'h1 << 3,
		S_SUM_WR   = 27'h1 << 4,
		S_Q_ROW    = 27'h1 << 5,
		S_Q_ROWL   = 27'h1 << 6,
		S_Q_PAIR   = 27'h1 << 7,
		S_Q_LOAD   = 27'h1 << 8,
		S_Q_DIV    = 27'h1 << 9,
		S_BR_RD    = 27'h1 << 10,
		S_BR_L1    = 27'h1 << 11,
		S_BR_L2    = 27'h1 << 12,
		S_BR_DIV   = 27'h1 << 13,
		S_ID1      = 27'h1 << 14,
		S_ID2      = 27'h1 << 15,
		S_ID3      = 27'h1 << 16,
		S_EMIT     = 27'h1 << 17,
		S_UPD_RA   = 27'h1 << 18,
		S_UPD_RB   = 27'h1 << 19,
		S_UPD_C    = 27'h1 << 20,
		S_UPD_W2   = 27'h1 << 21,
		S_NEXT     = 27'h1 << 22,
		S_FIN      = 27'h1 << 23,
		S_FIN1     = 27'h1 << 24,
		S_FIN2     = 27'h1 << 25,
		S_FIN3     = 27'h1 << 26
	} state_t;

	function automatic logic signed [CELL_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] hi;
		logic signed [WIDE_W-1:0] lo;
		hi = WIDE_W'(33'sh0_7FFF_FFFF);
		lo = -hi - WIDE_W'(1);
		if (v > hi) begin
			return hi[CELL_W-1:0];
		end else if (v < lo) begin
			return lo[CELL_W-1:0];
		end
		return v[CELL_W-1:0];
	endfunction

	function automatic logic [LEN_W-1:0] len_sat(input logic signed [WIDE_W-1:0] v);
		logic [WIDE_W-1:0] mag;
		mag = (v < 0) ? WIDE_W'(-v) : WIDE_W'(v);
		if (mag > WIDE_W'({LEN_W{1'b1}})) begin
			return {LEN_W{1'b1}};
		end
		return mag[LEN_W-1:0];
	endfunction

	function automatic logic signed [WIDE_W-1:0] half(input logic signed [WIDE_W-1:0] v);
		logic signed [WIDE_W-1:0] t;
		t = v + ((v < 0) ? WIDE_W'(1) : WIDE_W'(0));
		return t >>> 1;
	endfunction

endpackage

[rtl/nj_div.sv]
// Serial signed divider, one quotient bit per cycle, truncating toward zero.
// Does not use nj_pkg; the divisor must be non-zero and positive.
module nj_div #(
	parameter int DVW = 33,
	parameter int DSW = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic signed [DVW-1:0] dividend,
	input  logic [DSW-1:0]        divisor,
	output logic                  done,
	output logic signed [DVW:0]   quotient
);

	localparam int CW = $clog2(DVW + 1);

	logic           busy_q;
	logic           done_q;
	logic [CW-1:0]  cnt_q;
	logic [DVW-1:0] num_q;
	logic [DSW-1:0] rem_q;
	logic [DSW-1:0] dsr_q;
	logic           neg_q;
	logic [DSW:0]   rem_sh;
	logic           ge;
	logic [DSW:0]   rem_n;

	assign rem_sh = {rem_q, num_q[DVW-1]};
	assign ge     = rem_sh >= {1'b0, dsr_q};
	assign rem_n  = ge ? rem_sh - {1'b0, dsr_q} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DVW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend[DVW-1] ? DVW'(-dividend) : DVW'(dividend);
			neg_q <= dividend[DVW-1];
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DVW-2:0], ge};
			rem_q <= rem_n[DSW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed({1'b0, num_q}) : $signed({1'b0, num_q});

endmodule

[rtl/nj_engine.sv]
// Joining engine: distance and row-sum memories, the round sequencer and the branch arithmetic.
// Depends on nj_pkg and nj_div.
module nj_engine #(
	parameter int MAX_TAXA = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [nj_pkg::CNT_W-1:0]   taxon_count,
	input  logic                       load_valid,
	input  nj_pkg::load_t              load,
	output logic                       idle,
	output logic                       res_valid,
	input  logic                       res_ready,
	output nj_pkg::result_t            res
);

	localparam int AW    = $clog2(MAX_TAXA);
	localparam int DEPTH = 1 << (2 * AW);
	localparam int CW    = nj_pkg::CELL_W;
	localparam int WW    = nj_pkg::WIDE_W;
	localparam int NW    = nj_pkg::NODE_W;
	localparam int KW    = nj_pkg::CNT_W;
	localparam int LW    = nj_pkg::LEN_W;
	localparam int ACC_W = CW + AW;
	localparam int QW    = CW + 3;
	localparam int DVW   = CW + 1;
	localparam int DSW   = KW + 1;

	// Slots are physical rows; live rows keep their relative order, so the i-th live slot is
	// the i-th row of the shrunk matrix. Once a slot is renamed its diagonal cell holds its id.
	logic signed [CW-1:0] dist_mem [DEPTH];
	logic signed [CW-1:0] rs_mem [MAX_TAXA];

	nj_pkg::state_t state_q;

	logic [MAX_TAXA-1:0] alive_q;
	logic [MAX_TAXA-1:0] renamed_q;
	logic                diagz_q;
	logic [KW-1:0]       ntax_q;
	logic [KW-1:0]       n_q;
	logic [5:0]          join_q;
	logic [AW-1:0]       i_q;
	logic [AW-1:0]       j_q;
	logic [AW-1:0]       o1_q;
	logic [AW-1:0]       o2_q;
	logic                found_q;
	logic signed [QW-1:0]    minq_q;
	logic signed [ACC_W-1:0] acc_q;
	logic signed [CW-1:0]    rsi_q;
	logic signed [CW-1:0]    rs1_q;
	logic signed [CW-1:0]    cellv_q;
	logic signed [CW-1:0]    d12_q;
	logic signed [CW-1:0]    a_q;
	logic signed [CW-1:0]    tmp_q;
	logic signed [CW-1:0]    c00_q;
	logic [LW-1:0]       la_q;
	logic [LW-1:0]       lb_q;
	logic [NW-1:0]       id1_q;
	logic [NW-1:0]       id2_q;
	logic                last_q;

	logic signed [CW-1:0] dist_rdata;
	logic signed [CW-1:0] rs_rdata;
	logic [2*AW-1:0]      dm_raddr;
	logic [2*AW-1:0]      dm_waddr;
	logic signed [CW-1:0] dm_wdata;
	logic                 dm_we;
	logic [AW-1:0]        rs_raddr;
	logic                 rs_we;

	logic [KW-1:0]       ntax_c;
	logic [MAX_TAXA-1:0] mask_c;
	logic [AW:0]         first_c;
	logic [AW:0]         second_c;
	logic [AW:0]         nx_i;
	logic [AW:0]         nx_j;
	logic [KW-1:0]       dv_c;
	logic [NW-1:0]       new_id;
	logic signed [CW-1:0] sumv_c;
	logic signed [CW-1:0] updb_c;
	logic signed [CW-1:0] tmp_c;
	logic signed [QW-1:0] q_c;
	logic signed [WW-1:0] b1_c;
	logic signed [WW-1:0] b2_c;
	logic [LW-1:0]        flen_c;
	logic                 in_range;

	logic                  div_start;
	logic signed [DVW-1:0] div_dividend;
	logic [DSW-1:0]        div_divisor;
	logic                  div_done;
	logic signed [DVW:0]   div_quot;

	function automatic logic [AW:0] next_live(input logic [MAX_TAXA-1:0] m,
			input logic [AW-1:0] p, input logic incl);
		logic [AW:0] r;
		r = '0;
		for (int k = MAX_TAXA - 1; k >= 0; k--) begin
			if (m[k] && (((AW+1)'(k) > {1'b0, p}) || (incl && (AW'(k) == p)))) begin
				r = {1'b1, AW'(k)};
			end
		end
		return r;
	endfunction

	nj_div #(
		.DVW(DVW),
		.DSW(DSW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.done    (div_done),
		.quotient(div_quot)
	);

	always_comb begin
		if (taxon_count < KW'(2)) begin
			ntax_c = KW'(2);
		end else if (taxon_count > KW'(MAX_TAXA)) begin
			ntax_c = KW'(MAX_TAXA);
		end else begin
			ntax_c = taxon_count;
		end
		for (int k = 0; k < MAX_TAXA; k++) begin
			mask_c[k] = KW'(k) < ntax_c;
		end
	end

	assign first_c  = next_live(alive_q, '0, 1'b1);
	assign second_c = next_live(alive_q, first_c[AW-1:0], 1'b0);
	assign nx_i     = next_live(alive_q, i_q, 1'b0);
	assign nx_j     = next_live(alive_q, j_q, 1'b0);
	assign dv_c     = n_q - KW'(2);
	assign new_id   = NW'(ntax_q) + NW'(join_q);
	assign in_range = ({1'b0, load.row_index} < KW'(MAX_TAXA))
		&& ({1'b0, load.col_index} < KW'(MAX_TAXA));

	assign sumv_c = (diagz_q && (i_q == j_q)) ? '0 : dist_rdata;
	assign updb_c = (diagz_q && (j_q == o2_q)) ? '0 : dist_rdata;
	assign tmp_c  = nj_pkg::sat32(nj_pkg::half(WW'(a_q) + WW'(updb_c) - WW'(d12_q)));
	assign q_c    = QW'(cellv_q) - QW'(div_quot);
	assign b1_c   = nj_pkg::half(WW'(d12_q)) + WW'(div_quot);
	assign b2_c   = WW'(d12_q) - b1_c;
	assign flen_c = nj_pkg::len_sat(WW'(c00_q) + WW'(dist_rdata));

	always_comb begin
		div_start    = (state_q == nj_pkg::S_Q_LOAD) || (state_q == nj_pkg::S_BR_L2);
		div_dividend = (state_q == nj_pkg::S_Q_LOAD) ? DVW'(rsi_q) + DVW'(rs_rdata)
			: DVW'(rs1_q) - DVW'(rs_rdata);
		div_divisor  = (state_q == nj_pkg::S_Q_LOAD) ? DSW'(dv_c) : {dv_c, 1'b0};
	end

	always_comb begin
		dm_raddr = {i_q, j_q};
		rs_raddr = i_q;
		dm_we    = 1'b0;
		dm_waddr = {load.row_index[AW-1:0], load.col_index[AW-1:0]};
		dm_wdata = CW'(load.distance_value);
		rs_we    = 1'b0;
		case (state_q)
			nj_pkg::S_IDLE: begin
				dm_we = load_valid && in_range;
			end
			nj_pkg::S_Q_PAIR: begin
				rs_raddr = j_q;
			end
			nj_pkg::S_SUM_WR: begin
				rs_we = 1'b1;
			end
			nj_pkg::S_BR_RD: begin
				dm_raddr = {o1_q, o2_q};
				rs_raddr = o1_q;
			end
			nj_pkg::S_BR_L1: begin
				rs_raddr = o2_q;
			end
			nj_pkg::S_ID1: begin
				dm_raddr = {o1_q, o1_q};
			end
			nj_pkg::S_ID2: begin
				dm_raddr = {o2_q, o2_q};
			end
			nj_pkg::S_UPD_RA: begin
				dm_raddr = {o1_q, j_q};
			end
			nj_pkg::S_UPD_RB: begin
				dm_raddr = {o2_q, j_q};
			end
			nj_pkg::S_UPD_C: begin
				dm_we    = 1'b1;
				dm_waddr = {o1_q, j_q};
				dm_wdata = (j_q == o1_q) ? CW'(new_id) : tmp_c;
			end
			nj_pkg::S_UPD_W2: begin
				dm_we    = j_q != o1_q;
				dm_waddr = {j_q, o1_q};
				dm_wdata = tmp_q;
			end
			nj_pkg::S_FIN: begin
				dm_raddr = {first_c[AW-1:0], first_c[AW-1:0]};
			end
			nj_pkg::S_FIN1: begin
				dm_raddr = {first_c[AW-1:0], second_c[AW-1:0]};
			end
			nj_pkg::S_FIN2: begin
				dm_raddr = {second_c[AW-1:0], second_c[AW-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dm_we) begin
			dist_mem[dm_waddr] <= dm_wdata;
		end
		dist_rdata <= dist_mem[dm_raddr];
		if (rs_we) begin
			rs_mem[i_q] <= nj_pkg::sat32(WW'(acc_q));
		end
		rs_rdata <= rs_mem[rs_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= nj_pkg::S_IDLE;
			alive_q   <= '0;
			renamed_q <= '0;
			diagz_q   <= 1'b0;
			ntax_q    <= '0;
			n_q       <= '0;
			join_q    <= '0;
			found_q   <= 1'b0;
			last_q    <= 1'b0;
		end else begin
			case (state_q)
				nj_pkg::S_IDLE: begin
					if (load_valid && load.last_entry) begin
						ntax_q    <= ntax_c;
						n_q       <= ntax_c;
						alive_q   <= mask_c;
						renamed_q <= '0;
						diagz_q   <= 1'b0;
						join_q    <= '0;
						state_q   <= (ntax_c > KW'(2)) ? nj_pkg::S_SUM_INIT : nj_pkg::S_FIN;
					end
				end
				nj_pkg::S_SUM_INIT: begin
					i_q     <= first_c[AW-1:0];
					j_q     <= first_c[AW-1:0];
					acc_q   <= '0;
					state_q <= nj_pkg::S_SUM_RD;
				end
				nj_pkg::S_SUM_RD: begin
					state_q <= nj_pkg::S_SUM_ACC;
				end
				nj_pkg::S_SUM_ACC: begin
					acc_q <= acc_q + ACC_W'(sumv_c);
					if (nx_j[AW]) begin
						j_q     <= nx_j[AW-1:0];
						state_q <= nj_pkg::S_SUM_RD;
					end else begin
						state_q <= nj_pkg::S_SUM_WR;
					end
				end
				nj_pkg::S_SUM_WR: begin
					acc_q <= '0;
					j_q   <= first_c[AW-1:0];
					if (nx_i[AW]) begin
						i_q     <= nx_i[AW-1:0];
						state_q <= nj_pkg::S_SUM_RD;
					end else begin
						i_q     <= first_c[AW-1:0];
						found_q <= 1'b0;
						state_q <= nj_pkg::S_Q_ROW;
					end
				end
				nj_pkg::S_Q_ROW: begin
					state_q <= nj_pkg::S_Q_ROWL;
				end
				nj_pkg::S_Q_ROWL: begin
					rsi_q   <= rs_rdata;
					state_q <= nj_pkg::S_Q_PAIR;
				end
				nj_pkg::S_Q_PAIR, nj_pkg::S_Q_DIV: begin
					if ((state_q == nj_pkg::S_Q_PAIR) && (i_q != j_q)) begin
						state_q <= nj_pkg::S_Q_LOAD;
					end else if ((state_q == nj_pkg::S_Q_PAIR) || div_done) begin
						if ((state_q == nj_pkg::S_Q_DIV) && (!found_q || (q_c < minq_q))) begin
							found_q <= 1'b1;
							minq_q  <= q_c;
							o1_q    <= (i_q < j_q) ? i_q : j_q;
							o2_q    <= (i_q < j_q) ? j_q : i_q;
						end
						if (nx_j[AW]) begin
							j_q     <= nx_j[AW-1:0];
							state_q <= nj_pkg::S_Q_PAIR;
						end else if (nx_i[AW]) begin
							i_q     <= nx_i[AW-1:0];
							j_q     <= first_c[AW-1:0];
							state_q <= nj_pkg::S_Q_ROW;
						end else begin
							state_q <= nj_pkg::S_BR_RD;
						end
					end
				end
				nj_pkg::S_Q_LOAD: begin
					cellv_q <= dist_rdata;
					state_q <= nj_pkg::S_Q_DIV;
				end
				nj_pkg::S_BR_RD: begin
					state_q <= nj_pkg::S_BR_L1;
				end
				nj_pkg::S_BR_L1: begin
					d12_q   <= dist_rdata;
					rs1_q   <= rs_rdata;
					state_q <= nj_pkg::S_BR_L2;
				end
				nj_pkg::S_BR_L2: begin
					state_q <= nj_pkg::S_BR_DIV;
				end
				nj_pkg::S_BR_DIV: begin
					if (div_done) begin
						la_q    <= nj_pkg::len_sat(b1_c);
						lb_q    <= nj_pkg::len_sat(b2_c);
						state_q <= nj_pkg::S_ID1;
					end
				end
				nj_pkg::S_ID1: begin
					state_q <= nj_pkg::S_ID2;
				end
				nj_pkg::S_ID2: begin
					id1_q   <= renamed_q[o1_q] ? dist_rdata[NW-1:0] : NW'(o1_q);
					state_q <= nj_pkg::S_ID3;
				end
				nj_pkg::S_ID3: begin
					id2_q   <= renamed_q[o2_q] ? dist_rdata[NW-1:0] : NW'(o2_q);
					last_q  <= 1'b0;
					state_q <= nj_pkg::S_EMIT;
				end
				nj_pkg::S_EMIT: begin
					if (res_ready) begin
						j_q     <= first_c[AW-1:0];
						state_q <= last_q ? nj_pkg::S_IDLE : nj_pkg::S_UPD_RA;
					end
				end
				nj_pkg::S_UPD_RA: begin
					state_q <= nj_pkg::S_UPD_RB;
				end
				nj_pkg::S_UPD_RB: begin
					a_q     <= (diagz_q && (j_q == o1_q)) ? '0 : dist_rdata;
					state_q <= nj_pkg::S_UPD_C;
				end
				nj_pkg::S_UPD_C: begin
					tmp_q   <= tmp_c;
					state_q <= nj_pkg::S_UPD_W2;
				end
				nj_pkg::S_UPD_W2: begin
					if (nx_j[AW]) begin
						j_q     <= nx_j[AW-1:0];
						state_q <= nj_pkg::S_UPD_RA;
					end else begin
						state_q <= nj_pkg::S_NEXT;
					end
				end
				nj_pkg::S_NEXT: begin
					alive_q[o2_q]   <= 1'b0;
					renamed_q[o1_q] <= 1'b1;
					diagz_q         <= 1'b1;
					join_q          <= join_q + 6'd1;
					n_q             <= n_q - KW'(1);
					state_q <= (n_q > KW'(3)) ? nj_pkg::S_SUM_INIT : nj_pkg::S_FIN;
				end
				nj_pkg::S_FIN: begin
					state_q <= nj_pkg::S_FIN1;
				end
				nj_pkg::S_FIN1: begin
					c00_q   <= diagz_q ? '0 : dist_rdata;
					id1_q   <= renamed_q[first_c[AW-1:0]] ? dist_rdata[NW-1:0]
						: NW'(first_c[AW-1:0]);
					state_q <= nj_pkg::S_FIN2;
				end
				nj_pkg::S_FIN2: begin
					if (renamed_q[first_c[AW-1:0]]) begin
						la_q <= '0;
						lb_q <= flen_c;
					end else begin
						la_q <= flen_c >> 1;
						lb_q <= flen_c >> 1;
					end
					state_q <= nj_pkg::S_FIN3;
				end
				nj_pkg::S_FIN3: begin
					id2_q   <= renamed_q[second_c[AW-1:0]] ? dist_rdata[NW-1:0]
						: NW'(second_c[AW-1:0]);
					last_q  <= 1'b1;
					state_q <= nj_pkg::S_EMIT;
				end
				default: begin
					state_q <= nj_pkg::S_IDLE;
				end
			endcase
		end
	end

	assign idle      = state_q == nj_pkg::S_IDLE;
	assign res_valid = state_q == nj_pkg::S_EMIT;

	always_comb begin
		res.left_node    = id1_q;
		res.right_node   = id2_q;
		res.left_length  = la_q;
		res.right_length = lb_q;
		res.new_node     = new_id;
		res.last_join    = last_q;
	end

endmodule

[rtl/neighbor_joining_tree.sv]
// Top level of the neighbour-joining tree builder: stream ports, taxon count register, output stage.
// Depends on nj_pkg and nj_engine.
//
// Distance cells stream in at one item per cycle and are written straight into the on-chip
// distance memory; the item flagged tlast starts joining and the input then stays not ready
// until the final join has been handed to the output stage. With n active nodes a round runs
// the row sums, the pair search, the branch lengths and the matrix update in that order; the
// pair search dominates, set by the serial divider that forms each (ri+rj)/(n-2) and by the
// single read port of the distance memory. Results leave through a register, so one join may
// wait for m_axis_tready while the next round is already under way.
module neighbor_joining_tree #(
	parameter int MAX_TAXA = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// row_index[5:0], col_index[11:6], distance_value[35:12], zero fill[39:36]
	input  logic [nj_pkg::IN_W-1:0]     s_axis_tdata,
	input  logic                        s_axis_tlast,
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// left_node[6:0], right_node[13:7], left_length[37:14], right_length[61:38],
	// new_node[68:62], zero fill[71:69]
	output logic [nj_pkg::OUT_W-1:0]    m_axis_tdata,
	output logic                        m_axis_tlast,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [nj_pkg::CNT_W-1:0]    cfg_data
);

	logic [nj_pkg::CNT_W-1:0]  taxon_count_q;
	logic                      eng_idle;
	logic                      res_valid;
	logic                      res_ready;
	nj_pkg::result_t           res;
	nj_pkg::load_t             load;
	logic                      m_valid_q;
	logic [nj_pkg::OUT_W-1:0]  m_data_q;
	logic                      m_last_q;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = eng_idle;
	assign res_ready     = !m_valid_q || m_axis_tready;

	always_comb begin
		load.row_index      = s_axis_tdata[5:0];
		load.col_index      = s_axis_tdata[11:6];
		load.distance_value = s_axis_tdata[35:12];
		load.last_entry     = s_axis_tlast;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taxon_count_q <= 7'd64;
		end else if (cfg_valid) begin
			taxon_count_q <= cfg_data;
		end
	end

	nj_engine #(
		.MAX_TAXA(MAX_TAXA)
	) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.taxon_count(taxon_count_q),
		.load_valid (s_axis_tvalid && eng_idle),
		.load       (load),
		.idle       (eng_idle),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_data_q <= {3'b000, res.new_node, res.right_length, res.left_length,
				res.right_node, res.left_node};
			m_last_q <= res.last_join;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

endmodule

[rtl/nj_checker.sv]
// Port-level checks for the neighbour-joining tree builder, bound to its top level.
// Depends on nj_pkg for the port widths.
module nj_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_axis_tvalid,
	input logic                      s_axis_tready,
	input logic [nj_pkg::IN_W-1:0]   s_axis_tdata,
	input logic                      s_axis_tlast,
	input logic                      m_axis_tvalid,
	input logic                      m_axis_tready,
	input logic [nj_pkg::OUT_W-1:0]  m_axis_tdata,
	input logic                      m_axis_tlast,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [nj_pkg::CNT_W-1:0]  cfg_data
);

	// A final cell puts the block to work, so it takes no item in the next cycle.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
		else $error("input ready straight after the final cell");

	// The two nodes of a join are always distinct.
	a_distinct_nodes: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[6:0] != m_axis_tdata[13:7])
		else $error("join of a node with itself");

	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
		m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled result changed");

	a_hold_input: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
		s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tlast))
		else $error("waiting input item changed");

	a_cfg_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready && s_axis_tready && !$isunknown(cfg_data))
		else $error("taxon count written while joining");

endmodule

bind neighbor_joining_tree nj_checker u_nj_checker (.*);
